// ----- src/abl_pkg.sv -----
// abl_pkg: shared types, codes and fixed-point helpers for the affine line rasterizer
// depends on nothing; imported by affine_bresenham_line_raster, line_raster_checker and testbench
`default_nettype none

package abl_pkg;

  localparam int FRAC_BITS = 8;
  localparam int COEF_FRAC = 16;
  localparam int STAGES    = 7;

  typedef enum logic [1:0] {
    CMD_MOVE = 2'd0,
    CMD_LINE = 2'd1,
    CMD_STEP = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    REG_M_A           = 3'd0,
    REG_M_B           = 3'd1,
    REG_M_C           = 3'd2,
    REG_M_D           = 3'd3,
    REG_M_TX          = 3'd4,
    REG_M_TY          = 3'd5,
    REG_CANVAS_WIDTH  = 3'd6,
    REG_CANVAS_HEIGHT = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic [31:0]        color;
    logic               done;
  } pix_t;

  localparam logic signed [49:0] Q_MAX      = 50'sd2147483647;
  localparam logic signed [49:0] Q_MIN      = -50'sd2147483648;
  localparam logic signed [32:0] PIX_MAX    = 33'sd8388607;
  localparam logic signed [32:0] PIX_MIN    = -33'sd8388608;
  localparam logic signed [32:0] FRAC_ROUND = 33'((64'sd1 <<< FRAC_BITS) - 64'sd1);

  // floor of the product sum by 2^16, plus translation, saturated to 32 bits
  function automatic logic signed [31:0] affine_sat(input logic signed [64:0] sum,
                                                    input logic signed [31:0] t);
    logic signed [48:0] q;
    logic signed [49:0] s;
    logic signed [31:0] r;
    q = sum[64:COEF_FRAC];
    s = {q[48], q} + {{18{t[31]}}, t};
    if (s > Q_MAX) begin
      r = 32'sh7fffffff;
    end else if (s < Q_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  // truncate toward zero to an integer pixel, saturated to 24 bits
  function automatic logic signed [23:0] to_pixel(input logic signed [31:0] v);
    logic signed [32:0] b;
    logic signed [32:0] sh;
    logic signed [23:0] r;
    b  = {v[31], v} + (v[31] ? FRAC_ROUND : 33'sd0);
    sh = b >>> FRAC_BITS;
    if (sh > PIX_MAX) begin
      r = 24'sh7fffff;
    end else if (sh < PIX_MIN) begin
      r = 24'sh800000;
    end else begin
      r = sh[23:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/affine_bresenham_line_raster.sv -----
// affine_bresenham_line_raster: pen plotter front end, affine transform plus Bresenham stepper.
// Depends on abl_pkg. Takes one command per clock while s_tready is high and gives at most one pixel per command;
// a result passes the input register and the registered multiply, sum, saturate and pixel stages
// ahead of the registered Bresenham update, and the clip and address stage after it.
// Stalls on the output side fill bubbles first and then hold the input.
`default_nettype none

module affine_bresenham_line_raster
  import abl_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_write,
  input  wire logic [2:0]   cfg_addr,
  input  wire logic [31:0]  cfg_data,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [95:0]  s_tdata,   // x_coord, y_coord, pen_color
  input  wire logic [1:0]   s_tuser,   // command
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [103:0]      m_tdata,   // pixel_address, pixel_x, pixel_y, pixel_color
  output logic              m_tuser,   // pixel_valid
  output logic              m_tlast    // line_done
);

  logic signed [31:0] m_a, m_b, m_c, m_d, m_tx, m_ty;
  logic [12:0]        canvas_width, canvas_height;

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] load;

  cmd_t               cmd0, cmd1, cmd2, cmd3, cmd4;
  logic [31:0]        col0, col1, col2, col3, col4;
  logic signed [31:0] x0, y0;
  logic signed [63:0] prod_ax, prod_cy, prod_bx, prod_dy;
  logic signed [64:0] sum_x, sum_y;
  logic signed [31:0] q_x, q_y;
  logic signed [23:0] nx4, ny4;

  logic signed [23:0] cur_px, cur_py, pos_x, pos_y, end_x, end_y;
  logic [24:0]        delta_x, delta_y;
  logic signed [26:0] error_term;
  logic               dir_x, dir_y, line_active;
  logic [31:0]        latched_color;

  logic signed [23:0] cur_px_next, cur_py_next, pos_x_next, pos_y_next;
  logic signed [23:0] end_x_next, end_y_next;
  logic [24:0]        delta_x_next, delta_y_next;
  logic signed [26:0] error_term_next;
  logic               dir_x_next, dir_y_next, line_active_next;
  logic [31:0]        latched_color_next;
  pix_t               pix_next;
  logic               has_result_next;
  logic               idle_next;

  pix_t               pix5;
  logic               has5;
  logic               idle5;

  logic signed [24:0] dx_line, dy_line;
  logic [24:0]        adx_line, ady_line;
  logic signed [27:0] e2;
  logic               step_x, step_y;
  logic signed [27:0] err_sum;
  logic signed [23:0] sx_pos, sy_pos;

  logic               in_x, in_y, on_canvas;
  logic [25:0]        row_base;
  logic [26:0]        addr_sum;

  logic               out_valid_px, out_done;
  logic [23:0]        out_addr;
  logic signed [23:0] out_x, out_y;
  logic [31:0]        out_color;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      m_a           <= 32'sd65536;
      m_b           <= '0;
      m_c           <= '0;
      m_d           <= 32'sd65536;
      m_tx          <= '0;
      m_ty          <= '0;
      canvas_width  <= 13'd640;
      canvas_height <= 13'd480;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_addr))
        REG_M_A:           m_a <= cfg_data;
        REG_M_B:           m_b <= cfg_data;
        REG_M_C:           m_c <= cfg_data;
        REG_M_D:           m_d <= cfg_data;
        REG_M_TX:          m_tx <= cfg_data;
        REG_M_TY:          m_ty <= cfg_data;
        REG_CANVAS_WIDTH:  canvas_width <= cfg_data[12:0];
        REG_CANVAS_HEIGHT: canvas_height <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // stage ready chain
  always_comb begin
    load[STAGES-1] = !vld[STAGES-1] || m_tready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      load[k] = !vld[k] || load[k+1];
    end
  end

  assign s_tready = load[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (load[0]) vld[0] <= s_tvalid;
      for (int k = 1; k < STAGES - 1; k++) begin
        if (load[k]) vld[k] <= vld[k-1];
      end
      if (load[STAGES-1]) vld[STAGES-1] <= vld[STAGES-2] && has5;
    end
  end

  // transform pipeline
  always_ff @(posedge clk) begin
    if (load[0]) begin
      cmd0 <= cmd_t'(s_tuser);
      x0   <= s_tdata[31:0];
      y0   <= s_tdata[63:32];
      col0 <= s_tdata[95:64];
    end
    if (load[1]) begin
      cmd1    <= cmd0;
      col1    <= col0;
      prod_ax <= m_a * x0;
      prod_cy <= m_c * y0;
      prod_bx <= m_b * x0;
      prod_dy <= m_d * y0;
    end
    if (load[2]) begin
      cmd2  <= cmd1;
      col2  <= col1;
      sum_x <= {prod_ax[63], prod_ax} + {prod_cy[63], prod_cy};
      sum_y <= {prod_bx[63], prod_bx} + {prod_dy[63], prod_dy};
    end
    if (load[3]) begin
      cmd3 <= cmd2;
      col3 <= col2;
      q_x  <= affine_sat(sum_x, m_tx);
      q_y  <= affine_sat(sum_y, m_ty);
    end
    if (load[4]) begin
      cmd4 <= cmd3;
      col4 <= col3;
      nx4  <= to_pixel(q_x);
      ny4  <= to_pixel(q_y);
    end
  end

  // bresenham update
  assign dx_line  = {nx4[23], nx4} - {cur_px[23], cur_px};
  assign dy_line  = {ny4[23], ny4} - {cur_py[23], cur_py};
  assign adx_line = dx_line[24] ? 25'(-dx_line) : dx_line;
  assign ady_line = dy_line[24] ? 25'(-dy_line) : dy_line;

  assign e2      = {error_term, 1'b0};
  assign step_x  = e2 > -$signed({3'b000, delta_y});
  assign step_y  = e2 < $signed({3'b000, delta_x});
  assign err_sum = {error_term[26], error_term}
                   - (step_x ? $signed({3'b000, delta_y}) : 28'sd0)
                   + (step_y ? $signed({3'b000, delta_x}) : 28'sd0);
  assign sx_pos  = step_x ? (dir_x ? pos_x - 24'sd1 : pos_x + 24'sd1) : pos_x;
  assign sy_pos  = step_y ? (dir_y ? pos_y - 24'sd1 : pos_y + 24'sd1) : pos_y;

  always_comb begin
    cur_px_next        = cur_px;
    cur_py_next        = cur_py;
    pos_x_next         = pos_x;
    pos_y_next         = pos_y;
    end_x_next         = end_x;
    end_y_next         = end_y;
    delta_x_next       = delta_x;
    delta_y_next       = delta_y;
    error_term_next    = error_term;
    dir_x_next         = dir_x;
    dir_y_next         = dir_y;
    line_active_next   = line_active;
    latched_color_next = latched_color;
    pix_next           = '0;
    has_result_next    = 1'b0;
    idle_next          = 1'b0;
    case (cmd4)
      CMD_MOVE: begin
        cur_px_next      = nx4;
        cur_py_next      = ny4;
        line_active_next = 1'b0;
      end
      CMD_LINE: begin
        pos_x_next         = cur_px;
        pos_y_next         = cur_py;
        end_x_next         = nx4;
        end_y_next         = ny4;
        cur_px_next        = nx4;
        cur_py_next        = ny4;
        delta_x_next       = adx_line;
        delta_y_next       = ady_line;
        dir_x_next         = !(dx_line > 25'sd0);
        dir_y_next         = !(dy_line > 25'sd0);
        error_term_next    = $signed({2'b00, adx_line}) - $signed({2'b00, ady_line});
        latched_color_next = col4;
        pix_next.x         = cur_px;
        pix_next.y         = cur_py;
        pix_next.color     = col4;
        pix_next.done      = (cur_px == nx4) && (cur_py == ny4);
        line_active_next   = !pix_next.done;
        has_result_next    = 1'b1;
      end
      CMD_STEP: begin
        has_result_next = 1'b1;
        if (!line_active) begin
          pix_next.done = 1'b1;
          idle_next     = 1'b1;
        end else begin
          error_term_next  = err_sum[26:0];
          pos_x_next       = sx_pos;
          pos_y_next       = sy_pos;
          pix_next.x       = sx_pos;
          pix_next.y       = sy_pos;
          pix_next.color   = latched_color;
          pix_next.done    = (sx_pos == end_x) && (sy_pos == end_y);
          line_active_next = !pix_next.done;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_px        <= '0;
      cur_py        <= '0;
      pos_x         <= '0;
      pos_y         <= '0;
      end_x         <= '0;
      end_y         <= '0;
      delta_x       <= '0;
      delta_y       <= '0;
      error_term    <= '0;
      dir_x         <= 1'b0;
      dir_y         <= 1'b0;
      line_active   <= 1'b0;
      latched_color <= '0;
    end else if (load[5] && vld[4]) begin
      cur_px        <= cur_px_next;
      cur_py        <= cur_py_next;
      pos_x         <= pos_x_next;
      pos_y         <= pos_y_next;
      end_x         <= end_x_next;
      end_y         <= end_y_next;
      delta_x       <= delta_x_next;
      delta_y       <= delta_y_next;
      error_term    <= error_term_next;
      dir_x         <= dir_x_next;
      dir_y         <= dir_y_next;
      line_active   <= line_active_next;
      latched_color <= latched_color_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load[5]) begin
      pix5  <= pix_next;
      has5  <= has_result_next;
      idle5 <= idle_next;
    end
  end

  // clip and address, a step with no segment is never written
  assign in_x      = !pix5.x[23] && ({pix5.x[23], pix5.x} < $signed({12'b0, canvas_width}));
  assign in_y      = !pix5.y[23] && ({pix5.y[23], pix5.y} < $signed({12'b0, canvas_height}));
  assign on_canvas = in_x && in_y && !idle5;
  assign row_base  = pix5.y[12:0] * canvas_width;
  assign addr_sum  = {1'b0, row_base} + {14'b0, pix5.x[12:0]};

  always_ff @(posedge clk) begin
    if (load[STAGES-1]) begin
      out_valid_px <= on_canvas;
      out_addr     <= on_canvas ? addr_sum[23:0] : 24'd0;
      out_x        <= pix5.x;
      out_y        <= pix5.y;
      out_color    <= pix5.color;
      out_done     <= pix5.done;
    end
  end

  assign m_tvalid = vld[STAGES-1];
  assign m_tdata  = {out_color, out_y, out_x, out_addr};
  assign m_tuser  = out_valid_px;
  assign m_tlast  = out_done;

  a_active_not_at_end: assert property (@(posedge clk) disable iff (rst)
    line_active |-> (pos_x != end_x || pos_y != end_y))
    else $error("active segment sits on its end point");

  a_clipped_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[23:0] == 24'd0))
    else $error("clipped pixel carries an address");

  a_valid_on_canvas: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (!m_tdata[47] && !m_tdata[71]))
    else $error("written pixel has a negative coordinate");

endmodule

`default_nettype wire

// ----- test/line_raster_checker.sv -----
// line_raster_checker: watches the command, pixel and register ports of the affine line rasterizer,
// predicts every pixel from its own copy of the matrix, canvas and Bresenham state, and compares.
// Depends on abl_pkg for command and register codes; instantiated by testbench beside the dut.
module line_raster_checker
  import abl_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_data,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [95:0]  s_tdata,   // x_coord, y_coord, pen_color
  input  logic [1:0]   s_tuser,   // command
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [103:0] m_tdata,   // pixel_address, pixel_x, pixel_y, pixel_color
  input  logic         m_tuser,   // pixel_valid
  input  logic         m_tlast,   // line_done
  output int           pending,
  output int           failures,
  output int           pixels_checked,
  output int           pixels_clipped,
  output int           segment_ends
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        valid;
    logic [23:0] addr;
    logic [23:0] x;
    logic [23:0] y;
    logic [31:0] color;
    logic        done;
  } pixel_t;

  pixel_t expected_pixels[$];

  logic signed [31:0] coef_a, coef_b, coef_c, coef_d, shift_x, shift_y;
  logic [12:0]        canvas_w, canvas_h;
  logic signed [31:0] pen_qx, pen_qy;
  longint             px, py, gx, gy, run_x, run_y, slack;
  bit                 neg_x, neg_y, drawing;
  logic [31:0]        ink;

  // floor of the exact product sum by 2^16, plus translation, clamped to 32 bits
  function automatic logic signed [31:0] map_axis(input logic signed [31:0] k1,
                                                  input logic signed [31:0] u1,
                                                  input logic signed [31:0] k2,
                                                  input logic signed [31:0] u2,
                                                  input logic signed [31:0] t);
    logic signed [65:0] a1, b1, a2, b2, tt, acc;
    a1 = k1;
    b1 = u1;
    a2 = k2;
    b2 = u2;
    tt = t;
    acc = ((a1 * b1 + a2 * b2) >>> COEF_FRAC) + tt;
    if (acc > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end
    if (acc < -66'sd2147483648) begin
      return 32'sh80000000;
    end
    return acc[31:0];
  endfunction

  // truncate toward zero, clamp to the 24-bit device range
  function automatic longint pixel_of(input logic signed [31:0] q);
    longint v, r;
    v = q;
    r = (v < 0) ? -((-v) >>> FRAC_BITS) : (v >>> FRAC_BITS);
    if (r > 64'sd8388607) begin
      r = 64'sd8388607;
    end
    if (r < -64'sd8388608) begin
      r = -64'sd8388608;
    end
    return r;
  endfunction

  function automatic pixel_t plot(input bit done);
    pixel_t r;
    longint w, h;
    w = canvas_w;
    h = canvas_h;
    r.valid = (px >= 0) && (px < w) && (py >= 0) && (py < h);
    r.addr  = r.valid ? 24'(py * w + px) : 24'd0;
    r.x     = 24'(px);
    r.y     = 24'(py);
    r.color = ink;
    r.done  = done;
    return r;
  endfunction

  task automatic flag(input string what, input longint got, input longint want);
    $display("mismatch on %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    failures++;
  endtask

  task automatic set_register(input logic [2:0] idx, input logic [31:0] v);
    case (idx)
      REG_M_A:           coef_a = v;
      REG_M_B:           coef_b = v;
      REG_M_C:           coef_c = v;
      REG_M_D:           coef_d = v;
      REG_M_TX:          shift_x = v;
      REG_M_TY:          shift_y = v;
      REG_CANVAS_WIDTH:  canvas_w = v[12:0];
      REG_CANVAS_HEIGHT: canvas_h = v[12:0];
      default: ;
    endcase
  endtask

  task automatic trace_command(input logic [1:0] cmd, input logic signed [31:0] ux,
                               input logic signed [31:0] uy, input logic [31:0] color);
    logic signed [31:0] nx, ny;
    longint twice;
    bit done;
    pixel_t idle;
    case (cmd)
      CMD_MOVE: begin
        pen_qx  = map_axis(coef_a, ux, coef_c, uy, shift_x);
        pen_qy  = map_axis(coef_b, ux, coef_d, uy, shift_y);
        drawing = 1'b0;
      end
      CMD_LINE: begin
        nx     = map_axis(coef_a, ux, coef_c, uy, shift_x);
        ny     = map_axis(coef_b, ux, coef_d, uy, shift_y);
        px     = pixel_of(pen_qx);
        py     = pixel_of(pen_qy);
        gx     = pixel_of(nx);
        gy     = pixel_of(ny);
        pen_qx = nx;
        pen_qy = ny;
        run_x  = (gx >= px) ? gx - px : px - gx;
        run_y  = (gy >= py) ? gy - py : py - gy;
        neg_x  = !(px < gx);
        neg_y  = !(py < gy);
        slack  = run_x - run_y;
        ink    = color;
        done   = (px == gx) && (py == gy);
        drawing = !done;
        expected_pixels.push_back(plot(done));
      end
      CMD_STEP: begin
        if (!drawing) begin
          idle = '0;
          idle.done = 1'b1;
          expected_pixels.push_back(idle);
        end else begin
          twice = 2 * slack;
          if (twice > -run_y) begin
            slack = slack - run_y;
            px = neg_x ? px - 1 : px + 1;
          end
          if (twice < run_x) begin
            slack = slack + run_x;
            py = neg_y ? py - 1 : py + 1;
          end
          done = (px == gx) && (py == gy);
          drawing = !done;
          expected_pixels.push_back(plot(done));
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_pixel;
    pixel_t want;
    if (expected_pixels.size() == 0) begin
      flag("pixel transaction with nothing expected", m_tdata[23:0], 0);
      return;
    end
    want = expected_pixels.pop_front();
    pixels_checked++;
    if (!want.valid) begin
      pixels_clipped++;
    end
    if (want.done) begin
      segment_ends++;
    end
    if (m_tuser !== want.valid) flag("pixel_valid", m_tuser, want.valid);
    if (m_tdata[23:0] !== want.addr) flag("pixel_address", m_tdata[23:0], want.addr);
    if (m_tdata[47:24] !== want.x) flag("pixel_x", m_tdata[47:24], want.x);
    if (m_tdata[71:48] !== want.y) flag("pixel_y", m_tdata[71:48], want.y);
    if (m_tdata[103:72] !== want.color) flag("pixel_color", m_tdata[103:72], want.color);
    if (m_tlast !== want.done) flag("line_done", m_tlast, want.done);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      coef_a   = 32'sd65536;
      coef_b   = '0;
      coef_c   = '0;
      coef_d   = 32'sd65536;
      shift_x  = '0;
      shift_y  = '0;
      canvas_w = 13'd640;
      canvas_h = 13'd480;
      pen_qx   = '0;
      pen_qy   = '0;
      px       = 0;
      py       = 0;
      gx       = 0;
      gy       = 0;
      run_x    = 0;
      run_y    = 0;
      slack    = 0;
      neg_x    = 1'b0;
      neg_y    = 1'b0;
      drawing  = 1'b0;
      ink      = '0;
      expected_pixels.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        check_pixel();
      end
      if (cfg_write) begin
        set_register(cfg_addr, cfg_data);
      end
      if (s_tvalid && s_tready) begin
        trace_command(s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[95:64]);
      end
    end
    pending = expected_pixels.size();
  end

endmodule

// ----- test/testbench.sv -----
// testbench: top level for affine_bresenham_line_raster; drives reset, register writes and
// command transactions in bursts, stalls the pixel side, and reports the verdict.
// Depends on abl_pkg, the dut and line_raster_checker, which does all prediction and comparison.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import abl_pkg::*;

  localparam int         LIMIT      = 200000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic         clk       = 1'b0;
  logic         rst       = 1'b1;
  logic         cfg_write = 1'b0;
  logic [2:0]   cfg_addr  = '0;
  logic [31:0]  cfg_data  = '0;
  logic         s_tvalid  = 1'b0;
  logic         s_tready;
  logic [95:0]  s_tdata   = '0;   // x_coord, y_coord, pen_color
  logic [1:0]   s_tuser   = '0;   // command
  logic         m_tvalid;
  logic         m_tready  = 1'b0;
  logic [103:0] m_tdata;          // pixel_address, pixel_x, pixel_y, pixel_color
  logic         m_tuser;          // pixel_valid
  logic         m_tlast;          // line_done

  int pending, failures, pixels_checked, pixels_clipped, segment_ends;
  int items_sent   = 0;
  int burst_left   = 0;
  int settings_run = 0;
  int cycle_count  = 0;
  int last_x       = 0;
  int last_y       = 0;
  bit held         = 1'b0;

  always #10 clk = ~clk;

  affine_bresenham_line_raster dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  line_raster_checker watch (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_addr       (cfg_addr),
    .cfg_data       (cfg_data),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .m_tlast        (m_tlast),
    .pending        (pending),
    .failures       (failures),
    .pixels_checked (pixels_checked),
    .pixels_clipped (pixels_clipped),
    .segment_ends   (segment_ends)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] at(input int pix);
    return 32'(pix <<< FRAC_BITS);
  endfunction

  function automatic logic [31:0] user_q(input int pix);
    return 32'((pix <<< FRAC_BITS) + int'($urandom_range(0, 255)));
  endfunction

  function automatic int spread(input int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  task automatic send(input logic [1:0] cmd, input logic [31:0] x, input logic [31:0] y,
                      input logic [31:0] color);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {color, y, x};
    do @(posedge clk); while (!s_tready);
    burst_left--;
    if (cmd != CMD_UNUSED) begin
      items_sent++;
    end
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [31:0] v);
    cfg_write <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= v;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [31:0] a, input logic [31:0] b,
                               input logic [31:0] c, input logic [31:0] d,
                               input logic [31:0] tx, input logic [31:0] ty,
                               input logic [12:0] w, input logic [12:0] h);
    write_reg(REG_M_A, a);
    write_reg(REG_M_B, b);
    write_reg(REG_M_C, c);
    write_reg(REG_M_D, d);
    write_reg(REG_M_TX, tx);
    write_reg(REG_M_TY, ty);
    write_reg(REG_CANVAS_WIDTH, 32'(w));
    write_reg(REG_CANVAS_HEIGHT, 32'(h));
    cfg_write <= 1'b0;
    settings_run++;
  endtask

  // all pixels in, then room for moves still in the pipeline
  task automatic drain;
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // optional move, line near the current point, then a run of steps that may overshoot
  task automatic random_segment(input int reach, input int jog);
    int n;
    if ($urandom_range(0, 1) == 1) begin
      last_x = spread(reach);
      last_y = spread(reach);
      send(CMD_MOVE, user_q(last_x), user_q(last_y), $urandom);
    end
    last_x += spread(jog);
    last_y += spread(jog);
    send(CMD_LINE, user_q(last_x), user_q(last_y), $urandom);
    n = $urandom_range(0, 2 * jog + 4);
    repeat (n) send(CMD_STEP, $urandom, $urandom, $urandom);
  endtask

  task automatic run_phase(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c,
                           input logic [31:0] d, input logic [31:0] tx, input logic [31:0] ty,
                           input logic [12:0] w, input logic [12:0] h,
                           input int reach, input int jog, input int budget);
    int target;
    load_settings(a, b, c, d, tx, ty, w, h);
    target = items_sent + budget;
    while (items_sent < target) begin
      if ($urandom_range(0, 99) < 85) begin
        random_segment(reach, jog);
      end else begin
        send(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
      end
    end
    drain();
  endtask

  // pixel side: stall patterns that change when each random run ends, one long hold-off
  initial begin
    int mode;
    int left;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (!held && items_sent >= 900) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (399) @(posedge clk);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 200);
        end
        left--;
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 3) != 0);
          default: m_tready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  initial begin
    logic [31:0] ra, rb, rc, rd, rtx, rty;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed commands under the reset matrix and 640x480 canvas
    send(CMD_STEP, '0, '0, '0);
    send(CMD_LINE, at(3), at(1), 32'hFFFF_FFFF);
    repeat (4) send(CMD_STEP, '1, '1, '1);
    send(CMD_LINE, at(3), at(1), 32'h1234_5678);
    send(CMD_MOVE, at(12), at(9), '0);
    send(CMD_LINE, at(5), at(2), '0);
    repeat (3) send(CMD_STEP, '0, '0, '0);
    send(CMD_LINE, at(-4), at(482), 32'h00FF_00FF);
    repeat (2) send(CMD_STEP, '0, '0, '0);
    send(CMD_UNUSED, '1, '1, '1);
    send(CMD_MOVE, 32'hFFFF_FF80, 32'hFFFF_FF80, '1);
    send(CMD_LINE, 32'h0000_00C0, 32'h0000_0280, 32'hA5A5_A5A5);
    send(CMD_STEP, '0, '0, '0);
    send(CMD_MOVE, at(1), at(1), '0);
    send(CMD_STEP, '0, '0, '0);
    send(CMD_MOVE, 32'h7FFF_FFFF, 32'h8000_0000, '0);
    send(CMD_LINE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001);
    send(CMD_STEP, '0, '0, '0);
    send(CMD_MOVE, at(639), at(479), '0);
    send(CMD_LINE, at(640), at(480), 32'h0F0F_0F0F);
    send(CMD_STEP, '0, '0, '0);
    drain();

    run_phase(32'd65536, 32'd0, 32'd0, 32'd65536, 32'd0, 32'd0, 13'd640, 13'd480,
              700, 24, 210);
    run_phase(32'd163840, 32'd0, 32'd0, 32'hFFFF_0000, at(100), at(400), 13'd320, 13'd240,
              200, 12, 210);
    run_phase(32'd46341, 32'd46341, 32'hFFFF_4AFB, 32'd46341, at(64), at(64),
              13'd4096, 13'd4096, 3000, 24, 210);
    run_phase(32'd65536, 32'd0, 32'd0, 32'd65536, 32'd0, 32'd0, 13'd8191, 13'd8191,
              8191, 20, 210);
    run_phase(32'hFFFF_0000, 32'd0, 32'd0, 32'd65536, 32'h7FFF_FFFF, 32'h8000_0000,
              13'd0, 13'd1, 100, 16, 200);
    run_phase(32'd32768, 32'd1234, 32'hFFFF_EF1F, 32'd98304, at(-5), at(3), 13'd1, 13'd4096,
              300, 20, 210);
    run_phase(32'd0, 32'd0, 32'd0, 32'd0, 32'h0000_0180, 32'hFFFF_FE80, 13'd4096, 13'd0,
              50, 10, 150);
    run_phase(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 13'd4096, 13'd1, 50, 4, 150);
    ra  = 32'($urandom_range(0, 32'h3_FFFF)) - 32'h1_FFFF;
    rb  = 32'($urandom_range(0, 32'h3_FFFF)) - 32'h1_FFFF;
    rc  = 32'($urandom_range(0, 32'h3_FFFF)) - 32'h1_FFFF;
    rd  = 32'($urandom_range(0, 32'h3_FFFF)) - 32'h1_FFFF;
    rtx = 32'($urandom_range(0, 32'h1F_FFFF)) - 32'hF_FFFF;
    rty = 32'($urandom_range(0, 32'h1F_FFFF)) - 32'hF_FFFF;
    run_phase(ra, rb, rc, rd, rtx, rty, 13'($urandom_range(1, 4096)),
              13'($urandom_range(1, 4096)), 500, 16, 300);

    $display("covered %0d move, line and step commands under %0d register settings",
             items_sent, settings_run);
    $display("compared %0d pixels: %0d clipped, %0d segment ends",
             pixels_checked, pixels_clipped, segment_ends);
    if (failures == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
